[rtl/rfft10_pkg.sv]
`timescale 1ns / 1ps

package rfft10_pkg;

    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int COEF_FRAC_BITS_DEF = 16;
    localparam int NUM_POINTS         = 10;
    localparam int NUM_MULT           = 12;
    localparam int OUT_WIDTH          = 20;
    localparam int APB_DATA_W         = 32;
    localparam int APB_ADDR_W         = 3;

    // register index, taken from paddr above the byte offset
    localparam logic [APB_ADDR_W-3:0] REG_DIRECTION = '0;

    typedef enum logic {
        DIR_FWD = 1'b0,
        DIR_BWD = 1'b1
    } dir_t;

    // twiddle constants with 32 fraction bits
    localparam longint unsigned K_C1 = 64'd2400959709;
    localparam longint unsigned K_C2 = 64'd4084756634;
    localparam longint unsigned K_C3 = 64'd2524518436;
    localparam longint unsigned K_C4 = 64'd1073741824;
    localparam longint unsigned K_B1 = 64'd4801919417;
    localparam longint unsigned K_B2 = 64'd8169513268;
    localparam longint unsigned K_B3 = 64'd5049036871;
    localparam longint unsigned K_B4 = 64'd2147483648;

    // round a 32-fraction-bit constant to frac fraction bits, half up
    function automatic longint unsigned coef_q(longint unsigned q32, int frac);
        return (q32 + (64'd1 << (31 - frac))) >> (32 - frac);
    endfunction

    function automatic int byte_pad(int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

[rtl/real_fft10_halfcomplex_butterfly.sv]
`timescale 1ns / 1ps

// Size-10 real FFT butterfly built from two fused radix-5 real DFTs. Each stream
// transaction carries ten signed samples (s_tdata, point 0 in the lowest bits) and
// returns ten 20-bit saturated words (m_tdata, point 0 lowest); tlast passes through.
// The direction register (APB byte address 0, bit 0) selects forward real-to-halfcomplex
// (0) or backward halfcomplex-to-real (1); write it only while the block is empty.
// Constant products use COEF_FRAC_BITS fraction bits and round to nearest, ties away
// from zero. The datapath is six register stages (pre-add, magnitude, twelve constant
// multipliers, rounding, post-add, sum and saturate): it accepts one transaction per
// clock while the output side does not stall, and a result passes through these stage
// registers in that order before it is presented. Bubbles inside the pipeline are
// filled during a stall.
module real_fft10_halfcomplex_butterfly #(
    parameter int SAMPLE_WIDTH   = rfft10_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = rfft10_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    // apb configuration
    input  logic                                           psel,
    input  logic                                           penable,
    input  logic                                           pwrite,
    input  logic [rfft10_pkg::APB_ADDR_W-1:0]              paddr,
    input  logic [rfft10_pkg::APB_DATA_W-1:0]              pwdata,
    output logic [rfft10_pkg::APB_DATA_W-1:0]              prdata,
    output logic                                           pready,
    // input stream
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    // sample_0 .. sample_9, SAMPLE_WIDTH bits each, zero padded to bytes
    input  logic [rfft10_pkg::byte_pad(rfft10_pkg::NUM_POINTS*SAMPLE_WIDTH)-1:0] s_tdata,
    input  logic                                           s_tlast,
    // result stream
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    // value_0 .. value_9, 20 bits each
    output logic [rfft10_pkg::byte_pad(rfft10_pkg::NUM_POINTS*rfft10_pkg::OUT_WIDTH)-1:0]
                                                           m_tdata,
    output logic                                           m_tlast
);

    localparam int NP    = rfft10_pkg::NUM_POINTS;
    localparam int NM    = rfft10_pkg::NUM_MULT;
    localparam int OW    = rfft10_pkg::OUT_WIDTH;
    localparam int OUT_TDATA_W = rfft10_pkg::byte_pad(NP * OW);
    localparam int CW    = COEF_FRAC_BITS + 2;
    localparam int OPW   = SAMPLE_WIDTH + 3;
    localparam int PW    = OPW + CW;
    localparam int MW    = OPW + 3;
    localparam int AW0   = MW + 3;
    localparam int AW    = (AW0 > OW) ? AW0 : OW + 1;
    localparam int NSTG  = 6;

    localparam logic [CW-1:0] CK_C1 = CW'(rfft10_pkg::coef_q(rfft10_pkg::K_C1, COEF_FRAC_BITS));
    localparam logic [CW-1:0] CK_C2 = CW'(rfft10_pkg::coef_q(rfft10_pkg::K_C2, COEF_FRAC_BITS));
    localparam logic [CW-1:0] CK_C3 = CW'(rfft10_pkg::coef_q(rfft10_pkg::K_C3, COEF_FRAC_BITS));
    localparam logic [CW-1:0] CK_C4 = CW'(rfft10_pkg::coef_q(rfft10_pkg::K_C4, COEF_FRAC_BITS));
    localparam logic [CW-1:0] CK_B1 = CW'(rfft10_pkg::coef_q(rfft10_pkg::K_B1, COEF_FRAC_BITS));
    localparam logic [CW-1:0] CK_B2 = CW'(rfft10_pkg::coef_q(rfft10_pkg::K_B2, COEF_FRAC_BITS));
    localparam logic [CW-1:0] CK_B3 = CW'(rfft10_pkg::coef_q(rfft10_pkg::K_B3, COEF_FRAC_BITS));
    localparam logic [CW-1:0] CK_B4 = CW'(rfft10_pkg::coef_q(rfft10_pkg::K_B4, COEF_FRAC_BITS));

    localparam logic [CW-1:0] COEF_FWD [NM] = '{
        CK_C4, CK_C1, CK_C3, CK_C2, CK_C2, CK_C3,
        CK_C4, CK_C1, CK_C2, CK_C3, CK_C3, CK_C2
    };
    localparam logic [CW-1:0] COEF_BWD [NM] = '{
        CK_B4, CK_B1, CK_B2, CK_B3, CK_B2, CK_B3,
        CK_B4, CK_B1, CK_B2, CK_B3, CK_B2, CK_B3
    };

    localparam logic [PW:0] HALF = (PW + 1)'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [AW:0] Y_MAX = (AW + 1)'((1 << (OW - 1)) - 1);
    localparam logic signed [AW:0] Y_MIN = (AW + 1)'(-(1 << (OW - 1)));

    typedef struct packed {
        logic signed [OPW-1:0] xa;
        logic signed [OPW-1:0] xb;
        logic signed [OPW-1:0] xc;
        logic signed [OPW-1:0] xd;
        rfft10_pkg::dir_t      dir;
        logic                  last;
    } side_t;

    // configuration
    rfft10_pkg::dir_t                  direction_reg, direction_next;
    logic [rfft10_pkg::APB_ADDR_W-3:0] reg_index;
    logic                              cfg_wr;

    // pipeline control
    logic [NSTG-1:0] valid_reg, valid_next;
    logic [NSTG:0]   rdy;

    // stage payloads
    logic signed [OPW-1:0] op_reg   [NM];
    logic signed [OPW-1:0] op_next  [NM];
    logic [OPW-1:0]        mag_reg  [NM];
    logic [OPW-1:0]        mag_next [NM];
    logic [NM-1:0]         neg2_reg, neg2_next;
    logic [PW-1:0]         prod_reg  [NM];
    logic [PW-1:0]         prod_next [NM];
    logic [NM-1:0]         neg3_reg;
    logic signed [MW-1:0]  mprod_reg  [NM];
    logic signed [MW-1:0]  mprod_next [NM];
    side_t                 side_reg [4];
    side_t                 side1_next;
    logic signed [AW-1:0]  a_reg  [NP];
    logic signed [AW-1:0]  a_next [NP];
    logic signed [AW-1:0]  b_reg  [NP];
    logic signed [AW-1:0]  b_next [NP];
    logic                  last5_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                  m_tlast_reg;

    // apb
    assign pready    = 1'b1;
    assign reg_index = paddr[rfft10_pkg::APB_ADDR_W-1:2];
    assign cfg_wr    = psel & penable & pwrite & pready;

    always_comb begin
        direction_next = direction_reg;
        if (cfg_wr && reg_index == rfft10_pkg::REG_DIRECTION) begin
            direction_next = rfft10_pkg::dir_t'(pwdata[0]);
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_index == rfft10_pkg::REG_DIRECTION) begin
            prdata = {{(rfft10_pkg::APB_DATA_W-1){1'b0}}, direction_reg};
        end
    end

    // ready chain, a stage loads when empty or when it drains downstream
    always_comb begin
        rdy[NSTG] = m_tready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        valid_next[0] = rdy[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < NSTG; k++) begin
            valid_next[k] = rdy[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    assign s_tready = rdy[0];

    // stage 1: pre-adders and multiplier operand select
    always_comb begin
        logic signed [SAMPLE_WIDTH-1:0] xs;
        logic signed [OPW-1:0] x [NP];
        logic signed [OPW-1:0] s0, d0, s1, d1, tot, rs;
        logic signed [OPW-1:0] u0, v0, u1, v1, dd, ss;
        logic signed [OPW-1:0] bs0, bd0, bu0, bv0;
        for (int i = 0; i < NP; i++) begin
            xs   = signed'(s_tdata[i*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
            x[i] = OPW'(xs);
        end
        s0  = x[2] + x[8];
        d0  = x[2] - x[8];
        s1  = x[4] + x[6];
        d1  = x[4] - x[6];
        tot = s0 + s1;
        rs  = s0 - s1;
        u0  = x[3] + x[9];
        v0  = x[3] - x[9];
        u1  = x[5] + x[7];
        v1  = x[5] - x[7];
        dd  = v0 - v1;
        ss  = v0 + v1;
        bs0 = x[3] + x[7];
        bd0 = x[3] - x[7];
        bu0 = x[1] + x[5];
        bv0 = x[5] - x[1];
        side1_next.dir  = direction_reg;
        side1_next.last = s_tlast;
        side1_next.xa   = x[0];
        unique case (direction_reg)
            rfft10_pkg::DIR_FWD: begin
                op_next = '{tot, rs, d1, d0, d1, d0, dd, ss, u1, u0, u1, u0};
                side1_next.xb = tot;
                side1_next.xc = x[1];
                side1_next.xd = dd;
            end
            rfft10_pkg::DIR_BWD: begin
                op_next = '{bs0, bd0, x[4], x[8], x[8], x[4], bu0, bv0, x[6], x[2], x[2], x[6]};
                side1_next.xb = bs0;
                side1_next.xc = x[9];
                side1_next.xd = bu0;
            end
        endcase
    end

    // stage 2: sign and magnitude
    always_comb begin
        for (int j = 0; j < NM; j++) begin
            neg2_next[j] = op_reg[j][OPW-1];
            mag_next[j]  = op_reg[j][OPW-1] ? OPW'(-op_reg[j]) : OPW'(op_reg[j]);
        end
    end

    // stage 3: constant multipliers
    always_comb begin
        for (int j = 0; j < NM; j++) begin
            if (side_reg[1].dir == rfft10_pkg::DIR_FWD) begin
                prod_next[j] = PW'(mag_reg[j]) * PW'(COEF_FWD[j]);
            end else begin
                prod_next[j] = PW'(mag_reg[j]) * PW'(COEF_BWD[j]);
            end
        end
    end

    // stage 4: round magnitude half up, restore sign
    always_comb begin
        logic [PW:0]         rnd;
        logic signed [MW-1:0] q;
        for (int j = 0; j < NM; j++) begin
            rnd           = {1'b0, prod_reg[j]} + HALF;
            q             = signed'({1'b0, rnd[COEF_FRAC_BITS +: MW-1]});
            mprod_next[j] = neg3_reg[j] ? -q : q;
        end
    end

    // stage 5: butterfly terms, each result is a_reg + b_reg
    always_comb begin
        logic signed [AW-1:0] m [NM];
        logic signed [AW-1:0] xa, xb, xc, xd;
        logic signed [AW-1:0] base, ob, p, mm, op, om, f1, f2;
        for (int j = 0; j < NM; j++) begin
            m[j] = AW'(mprod_reg[j]);
        end
        xa   = AW'(side_reg[3].xa);
        xb   = AW'(side_reg[3].xb);
        xc   = AW'(side_reg[3].xc);
        xd   = AW'(side_reg[3].xd);
        base = xa - m[0];
        unique case (side_reg[3].dir)
            rfft10_pkg::DIR_FWD: begin
                ob = xc + m[6];
                p  = '0;
                mm = '0;
                op = '0;
                om = '0;
                f1 = '0;
                f2 = '0;
                a_next = '{xa + xb, ob, -m[8], base, -m[2], ob, m[10], base, m[4], xc - xd};
                b_next = '{AW'(0), m[7], -m[9], m[1], -m[3], -m[7], -m[11], -m[1], -m[5],
                           AW'(0)};
            end
            rfft10_pkg::DIR_BWD: begin
                ob = xc - m[6];
                p  = base + m[1];
                mm = base - m[1];
                op = ob + m[7];
                om = ob - m[7];
                f1 = -m[8] - m[9];
                f2 = m[10] - m[11];
                a_next = '{xa + (xb <<< 1), xc + (xd <<< 1), p, f1, mm, om, mm, -om, p, f1};
                b_next = '{AW'(0), AW'(0), -(m[2] + m[3]), -op, m[4] - m[5], -f2,
                           m[5] - m[4], -f2, m[2] + m[3], op};
            end
        endcase
    end

    // stage 6: final add and saturation
    always_comb begin
        logic signed [AW:0] y;
        m_tdata_next = '0;
        for (int i = 0; i < NP; i++) begin
            y = (AW + 1)'(a_reg[i]) + (AW + 1)'(b_reg[i]);
            if (y > Y_MAX) begin
                m_tdata_next[i*OW +: OW] = Y_MAX[OW-1:0];
            end else if (y < Y_MIN) begin
                m_tdata_next[i*OW +: OW] = Y_MIN[OW-1:0];
            end else begin
                m_tdata_next[i*OW +: OW] = y[OW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= rfft10_pkg::DIR_FWD;
            valid_reg     <= '0;
        end else begin
            direction_reg <= direction_next;
            valid_reg     <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            op_reg      <= op_next;
            side_reg[0] <= side1_next;
        end
        if (rdy[1]) begin
            mag_reg     <= mag_next;
            neg2_reg    <= neg2_next;
            side_reg[1] <= side_reg[0];
        end
        if (rdy[2]) begin
            prod_reg    <= prod_next;
            neg3_reg    <= neg2_reg;
            side_reg[2] <= side_reg[1];
        end
        if (rdy[3]) begin
            mprod_reg   <= mprod_next;
            side_reg[3] <= side_reg[2];
        end
        if (rdy[4]) begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            last5_reg <= side_reg[3].last;
        end
        if (rdy[5]) begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= last5_reg;
        end
    end

    assign m_tvalid = valid_reg[NSTG-1];
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

[rtl/rfft10_checker.sv]
`timescale 1ns / 1ps

module rfft10_checker (
    input logic                                           aclk,
    input logic                                           aresetn,
    input logic                                           psel,
    input logic                                           penable,
    input logic                                           pwrite,
    input logic [rfft10_pkg::APB_ADDR_W-1:0]              paddr,
    input logic [rfft10_pkg::APB_DATA_W-1:0]              pwdata,
    input logic [rfft10_pkg::APB_DATA_W-1:0]              prdata,
    input logic                                           pready,
    input logic                                           s_tready,
    input logic                                           m_tvalid,
    input logic                                           m_tready,
    // value_0 .. value_9
    input logic [rfft10_pkg::byte_pad(rfft10_pkg::NUM_POINTS*rfft10_pkg::OUT_WIDTH)-1:0]
                                                          m_tdata,
    input logic                                           m_tlast
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // a draining output never blocks the input side
    a_ready_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    // input only stalls behind a waiting result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // direction write reads back
    a_dir_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready
            && paddr[rfft10_pkg::APB_ADDR_W-1:2] == rfft10_pkg::REG_DIRECTION
        |=> paddr[rfft10_pkg::APB_ADDR_W-1:2] != rfft10_pkg::REG_DIRECTION
            || prdata[0] == $past(pwdata[0]))
        else $error("direction readback mismatch");

endmodule

bind real_fft10_halfcomplex_butterfly rfft10_checker u_rfft10_checker (.*);

[tb/sv/real_fft10_halfcomplex_butterfly_tb.sv]
`timescale 1ns / 1ps

module real_fft10_halfcomplex_butterfly_tb;

    localparam int NP       = rfft10_pkg::NUM_POINTS;
    localparam int OWD      = rfft10_pkg::OUT_WIDTH;
    localparam int AAW      = rfft10_pkg::APB_ADDR_W;
    localparam int ADW      = rfft10_pkg::APB_DATA_W;
    localparam int SW       = rfft10_pkg::SAMPLE_WIDTH_DEF;
    localparam int FRAC     = rfft10_pkg::COEF_FRAC_BITS_DEF;
    localparam int IN_W     = rfft10_pkg::byte_pad(NP * SW);
    localparam int OUT_W    = rfft10_pkg::byte_pad(NP * OWD);
    localparam longint OUT_HI = (64'sd1 <<< (OWD - 1)) - 1;
    localparam longint OUT_LO = -(64'sd1 <<< (OWD - 1));
    localparam longint unsigned COEF_TWO = 64'd8589934592;
    localparam logic [AAW-1:0] ADDR_DIRECTION = {rfft10_pkg::REG_DIRECTION, 2'b00};
    localparam logic [AAW-1:0] ADDR_UNMAPPED  = {1'b1, 2'b00};
    localparam int LONG_HOLD_CYCLES = 100;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int PHASES           = 9;
    localparam int PHASE_ITEMS      = 200;

    typedef struct packed {
        logic [NP-1:0][OWD-1:0] val;
        logic                   last;
    } fft10_out_t;

    class fft10_scoreboard;
        rfft10_pkg::dir_t dir;
        fft10_out_t       due[$];
        int               fails;

        function new();
            dir   = rfft10_pkg::DIR_FWD;
            fails = 0;
        endfunction

        function void write_reg(logic [AAW-1:0] addr, logic [ADW-1:0] data);
            if (addr[AAW-1:2] == rfft10_pkg::REG_DIRECTION) dir = rfft10_pkg::dir_t'(data[0]);
        endfunction

        // constant product, rounded to nearest with ties away from zero
        function longint mulr(longint unsigned q32, longint x);
            longint unsigned c;
            longint unsigned mag;
            longint unsigned q;
            c   = (q32 + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
            mag = (x < 0) ? longint'(-x) : x;
            q   = (mag * c + (64'd1 << (FRAC - 1))) >> FRAC;
            return (x < 0) ? -longint'(q) : longint'(q);
        endfunction

        function logic [OWD-1:0] clamp(longint v);
            longint r;
            r = v;
            if (r > OUT_HI) r = OUT_HI;
            if (r < OUT_LO) r = OUT_LO;
            return r[OWD-1:0];
        endfunction

        function void note_input(logic [IN_W-1:0] d, logic last);
            longint x[NP];
            longint y[NP];
            longint s0, d0, s1, d1, tot, base, rot, p, m, e1, e2;
            longint u0, v0, u1, v1, dd, ss, ob, orot, op, om, f1, f2;
            fft10_out_t e;
            for (int i = 0; i < NP; i++) x[i] = longint'($signed(d[SW*i +: SW]));
            if (dir == rfft10_pkg::DIR_FWD) begin
                s0 = x[2] + x[8];  d0 = x[2] - x[8];
                s1 = x[4] + x[6];  d1 = x[4] - x[6];
                tot  = s0 + s1;
                base = x[0] - mulr(rfft10_pkg::K_C4, tot);
                rot  = mulr(rfft10_pkg::K_C1, s0 - s1);
                y[0] = x[0] + tot;
                y[3] = base + rot;
                y[7] = base - rot;
                y[4] = -mulr(rfft10_pkg::K_C3, d1) - mulr(rfft10_pkg::K_C2, d0);
                y[8] = mulr(rfft10_pkg::K_C2, d1) - mulr(rfft10_pkg::K_C3, d0);
                u0 = x[3] + x[9];  v0 = x[3] - x[9];
                u1 = x[5] + x[7];  v1 = x[5] - x[7];
                dd   = v0 - v1;
                ss   = v0 + v1;
                ob   = x[1] + mulr(rfft10_pkg::K_C4, dd);
                orot = mulr(rfft10_pkg::K_C1, ss);
                y[1] = ob + orot;
                y[5] = ob - orot;
                y[2] = -mulr(rfft10_pkg::K_C2, u1) - mulr(rfft10_pkg::K_C3, u0);
                y[6] = mulr(rfft10_pkg::K_C3, u1) - mulr(rfft10_pkg::K_C2, u0);
                y[9] = x[1] - dd;
            end else begin
                s0 = x[3] + x[7];  d0 = x[3] - x[7];
                base = x[0] - mulr(rfft10_pkg::K_B4, s0);
                rot  = mulr(rfft10_pkg::K_B1, d0);
                p  = base + rot;
                m  = base - rot;
                e1 = mulr(rfft10_pkg::K_B2, x[4]) + mulr(rfft10_pkg::K_B3, x[8]);
                e2 = mulr(rfft10_pkg::K_B2, x[8]) - mulr(rfft10_pkg::K_B3, x[4]);
                y[0] = x[0] + mulr(COEF_TWO, s0);
                y[2] = p - e1;
                y[8] = p + e1;
                y[4] = m + e2;
                y[6] = m - e2;
                u0 = x[1] + x[5];  v0 = x[5] - x[1];
                ob   = x[9] - mulr(rfft10_pkg::K_B4, u0);
                orot = mulr(rfft10_pkg::K_B1, v0);
                op = ob + orot;
                om = ob - orot;
                f1 = -mulr(rfft10_pkg::K_B2, x[6]) - mulr(rfft10_pkg::K_B3, x[2]);
                f2 = mulr(rfft10_pkg::K_B2, x[2]) - mulr(rfft10_pkg::K_B3, x[6]);
                y[1] = x[9] + mulr(COEF_TWO, u0);
                y[3] = f1 - op;
                y[9] = f1 + op;
                y[5] = om - f2;
                y[7] = -om - f2;
            end
            for (int i = 0; i < NP; i++) e.val[i] = clamp(y[i]);
            e.last = last;
            due.push_back(e);
        endfunction

        function void check_result(logic [OUT_W-1:0] d, logic last);
            fft10_out_t e;
            logic [OWD-1:0] act;
            if (due.size() == 0) begin
                $error("result transaction with nothing expected");
                fails++;
                return;
            end
            e = due.pop_front();
            for (int i = 0; i < NP; i++) begin
                act = d[OWD*i +: OWD];
                if (act !== e.val[i]) begin
                    $error("value_%0d expected %0d actual %0d", i,
                           $signed(e.val[i]), $signed(act));
                    fails++;
                end
            end
            if (last !== e.last) begin
                $error("batch_end expected %0b actual %0b", e.last, last);
                fails++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [AAW-1:0]        paddr;
    logic [ADW-1:0]        pwdata;
    logic [ADW-1:0]        prdata;
    logic                  pready;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  m_tlast;

    fft10_scoreboard sb = new();
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  long_hold;
    int  quiet_cycles;

    real_fft10_halfcomplex_butterfly uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_input(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side backpressure
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                long_hold = 1'b0;
            end else if ($urandom_range(0, 99) < rx_idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic apb_write(input logic [AAW-1:0] addr,
                             input logic [ADW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(addr, data);
        @(posedge aclk);
    endtask

    task automatic send_vec(input logic [IN_W-1:0] d, input logic last);
        s_tdata  <= d;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic sender_gap();
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    task automatic drain(input int extra);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.due.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    function automatic logic [SW-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return {1'b0, {(SW-1){1'b1}}};
            1: return {1'b1, {(SW-1){1'b0}}};
            2: return SW'(int'($urandom_range(0, 15)) - 8);
            default: return SW'($urandom);
        endcase
    endfunction

    task automatic send_directed();
        logic [IN_W-1:0] d;
        logic [SW-1:0]   hi;
        logic [SW-1:0]   lo;
        hi = {1'b0, {(SW-1){1'b1}}};
        lo = {1'b1, {(SW-1){1'b0}}};
        for (int k = 0; k < 12; k++) begin
            for (int i = 0; i < NP; i++) begin
                case (k)
                    0: d[SW*i +: SW] = '0;
                    1: d[SW*i +: SW] = hi;
                    2: d[SW*i +: SW] = lo;
                    3: d[SW*i +: SW] = (i % 2 == 1) ? lo : hi;
                    4: d[SW*i +: SW] = (i % 2 == 1) ? hi : lo;
                    5: d[SW*i +: SW] = (i == 0) ? hi : '0;
                    6: d[SW*i +: SW] = (i == 1) ? lo : '0;
                    7: d[SW*i +: SW] = '1;
                    8: d[SW*i +: SW] = (i == 2 || i == 6 || i == 3 || i == 7) ? hi : lo;
                    9: d[SW*i +: SW] = (i == 2 || i == 6 || i == 3 || i == 7) ? lo : hi;
                    default: d[SW*i +: SW] = SW'($urandom);
                endcase
            end
            send_vec(d, k[0]);
        end
    endtask

    task automatic send_random();
        logic [IN_W-1:0] d;
        for (int i = 0; i < NP; i++) d[SW*i +: SW] = rand_sample();
        send_vec(d, $urandom_range(0, 7) == 0);
    endtask

    initial begin
        aresetn     <= 1'b0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        long_hold   = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed vectors in both directions, upper register bits written random or all set
        apb_write(ADDR_DIRECTION, {$urandom} & ~32'd1);
        send_directed();
        drain(10);
        apb_write(ADDR_DIRECTION, '1);
        apb_write(ADDR_UNMAPPED, '0);
        send_directed();
        drain(10);

        for (int ph = 0; ph < PHASES; ph++) begin
            apb_write(ADDR_DIRECTION, {$urandom} & ~32'd1 | 32'(ph % 2));
            if ($urandom_range(0, 1)) apb_write(ADDR_UNMAPPED, $urandom);
            tx_idle_pct = (ph == 1 || ph == PHASES - 1) ? 0 : ((ph % 3 == 0) ? 40 : 15);
            rx_idle_pct = (ph == 1 || ph == PHASES - 1) ? 0 : ((ph % 3 == 1) ? 40 : 15);
            if (ph == 2) long_hold = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 3 && n == PHASE_ITEMS / 2) drain(0);
                sender_gap();
                send_random();
            end
            drain(10);
        end

        drain(20);
        if (sb.fails == 0 && sb.due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
